/* hw/rtl/efja_pkg.sv */
// Shared types, widths and helpers for the earliest-finish job assigner.
`default_nettype none

package efja_pkg;

  localparam int WORKERS     = 16;
  localparam int WIDX_W      = $clog2(WORKERS);
  localparam int CNT_W       = WIDX_W + 1;
  localparam int NW_W        = 5;
  localparam int FAC_W       = 16;
  localparam int SIZE_W      = 16;
  localparam int PROD_W      = FAC_W + SIZE_W;
  localparam int TIME_W      = 48;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int IN_FIELDS_W = WIDX_W + FAC_W + SIZE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = WIDX_W + 2 * TIME_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [NW_W-1:0]   NW_RESET = NW_W'(WORKERS);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_JOB  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [WIDX_W-1:0]  widx;
    logic [FAC_W-1:0]   factor;
    logic [SIZE_W-1:0]  size;
    logic               last;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CNT_W-1:0] active_count(input logic [NW_W-1:0] nw_cfg);
    logic [CNT_W-1:0] c;
    c = CNT_W'(nw_cfg);
    if (nw_cfg == '0) begin
      c = CNT_W'(1);
    end else if (CNT_W'(nw_cfg) > CNT_W'(WORKERS) || nw_cfg > NW_W'(WORKERS)) begin
      c = CNT_W'(WORKERS);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/efja_front.sv */
// Input stage that accepts requests, classifies them and feeds the queue.
`default_nettype none

module efja_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: worker_index, worker_factor, job_size, zero fill.
  input  wire [efja_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Field: cmd.
  input  wire                               in_tuser,
  input  wire                               in_tlast,
  input  efja_pkg::q_stat_t                 q_stat,
  output logic                              push,
  output efja_pkg::req_t                    push_req
);
  import efja_pkg::*;

  logic buf_vld_r;
  logic buf_vld_nxt;
  req_t buf_r;
  req_t req_dec;
  logic accept;

  always_comb begin
    req_dec = '0;
    req_dec.cmd = cmd_t'(in_tuser);
    if (req_dec.cmd == CMD_LOAD) begin
      req_dec.widx   = in_tdata[WIDX_W-1:0];
      req_dec.factor = in_tdata[WIDX_W+FAC_W-1:WIDX_W];
    end else begin
      req_dec.size = in_tdata[IN_FIELDS_W-1:WIDX_W+FAC_W];
      req_dec.last = in_tlast;
    end
  end

  assign push      = buf_vld_r && !q_stat.full;
  assign in_tready = !buf_vld_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push_req  = buf_r;

  always_comb begin
    buf_vld_nxt = buf_vld_r;
    if (accept) begin
      buf_vld_nxt = 1'b1;
    end else if (push) begin
      buf_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
    end else begin
      buf_vld_r <= buf_vld_nxt;
    end
    if (accept) begin
      buf_r <= req_dec;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/efja_queue.sv */
// Small request queue between the front and the scheduling engine.
`default_nettype none

module efja_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  efja_pkg::req_t     push_req,
  input  wire                pop,
  output efja_pkg::req_t     head,
  output efja_pkg::q_stat_t  stat
);
  import efja_pkg::*;

  req_t               slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    cnt_r;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/efja_engine.sv */
// Scheduling engine: factor and finish-time stores, scans and result register.
`default_nettype none

module efja_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [efja_pkg::NW_W-1:0]          nw_cfg,
  input  efja_pkg::q_stat_t                 q_stat,
  input  efja_pkg::req_t                    q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // Fields from bit 0: assigned_worker, finish_time, makespan, zero fill.
  output logic [efja_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import efja_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_MUL,
    S_UPD,
    S_MAX,
    S_EMIT
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [CNT_W-1:0]    nw;
  logic [CNT_W-1:0]    nw_m1;
  logic [WIDX_W-1:0]   last_idx;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    jobs_r;
  logic                chk_r;
  logic [WIDX_W-1:0]   chk_idx_r;
  logic [WIDX_W-1:0]   pick_r;
  logic [SIZE_W-1:0]   size_r;
  logic                last_r;
  logic [TIME_W-1:0]   min_r;
  logic [TIME_W-1:0]   max_r;
  logic [TIME_W-1:0]   fin_r;
  logic [PROD_W-1:0]   prod_r;
  logic [TIME_W-1:0]   t_r;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   t_new;
  logic                issue;
  logic                scan_done;
  logic                out_free;
  logic                is_job;
  logic [WIDX_W-1:0]   rd_addr;
  logic [TIME_W-1:0]   rd_data_r;
  logic                rd_hit_r;
  logic [TIME_W-1:0]   rd_val;
  logic [WORKERS-1:0]  fin_vld_r;
  logic [TIME_W-1:0]   fin_mem [WORKERS];
  logic [FAC_W-1:0]    fac_mem [WORKERS];
  logic [FAC_W-1:0]    fac_rd_r;
  logic                fac_we;
  logic                out_tvalid_r;
  logic [WIDX_W-1:0]   out_worker_r;
  logic [TIME_W-1:0]   out_finish_r;
  logic [TIME_W-1:0]   out_span_r;
  logic                out_last_r;

  assign nw        = active_count(nw_cfg);
  assign nw_m1     = nw - CNT_W'(1);
  assign last_idx  = nw_m1[WIDX_W-1:0];
  assign issue     = (state_r == S_SCAN || state_r == S_MAX) && (idx_r < nw);
  assign rd_addr   = issue ? idx_r[WIDX_W-1:0] : pick_r;
  assign rd_val    = rd_hit_r ? rd_data_r : '0;
  assign scan_done = chk_r && (chk_idx_r == last_idx);
  assign out_free  = !out_tvalid_r || out_tready;
  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign is_job    = (q_head.cmd == CMD_JOB);
  assign fac_we    = q_pop && !is_job;
  assign sum       = {1'b0, fin_r} + (TIME_W+1)'(prod_r);
  assign t_new     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_span_r, out_finish_r, out_worker_r});

  always_ff @(posedge clk) begin
    rd_data_r <= fin_mem[rd_addr];
    rd_hit_r  <= fin_vld_r[rd_addr];
    if (state_r == S_UPD) begin
      fin_mem[pick_r] <= t_new;
    end
  end

  always_ff @(posedge clk) begin
    fac_rd_r <= fac_mem[pick_r];
    if (fac_we) begin
      fac_mem[q_head.widx] <= q_head.factor;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop && is_job) begin
          state_nxt = (jobs_r < nw) ? S_READ : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = last_r ? S_MAX : S_EMIT;
      S_MAX: begin
        if (scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      jobs_r       <= '0;
      idx_r        <= '0;
      chk_r        <= 1'b0;
      fin_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_r     <= issue;
      chk_idx_r <= idx_r[WIDX_W-1:0];
      if (issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (out_tvalid_r && out_tready && state_r != S_EMIT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop && is_job) begin
            size_r <= q_head.size;
            last_r <= q_head.last;
            idx_r  <= '0;
            if (jobs_r < nw) begin
              pick_r <= jobs_r[WIDX_W-1:0];
              jobs_r <= jobs_r + CNT_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (chk_r && (chk_idx_r == '0 || rd_val < min_r)) begin
            min_r  <= rd_val;
            pick_r <= chk_idx_r;
          end
        end
        S_MUL: begin
          fin_r  <= rd_val;
          prod_r <= PROD_W'(fac_rd_r) * PROD_W'(size_r);
        end
        S_UPD: begin
          fin_vld_r[pick_r] <= 1'b1;
          t_r   <= t_new;
          idx_r <= '0;
          max_r <= '0;
        end
        S_MAX: begin
          if (chk_r && rd_val > max_r) begin
            max_r <= rd_val;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_worker_r <= pick_r;
            out_finish_r <= t_r;
            out_last_r   <= last_r;
            out_span_r   <= last_r ? max_r : '0;
            if (last_r) begin
              fin_vld_r <= '0;
              jobs_r    <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/earliest_finish_job_assigner_top.sv */
// Top level of the earliest-finish job assigner.
`default_nettype none

// Requests pass an input register and a four-entry queue before the scheduling engine, so
// loads and jobs keep arriving while a result waits at the output. The engine writes each
// factor load into the factor store from its idle state. While the batch is still filling
// workers in order, a job goes straight to the next worker; afterwards the single read
// port of the finish-time store is walked one worker per cycle over the active workers
// to find the earliest finish. A job that closes a batch then walks the active workers
// again for the makespan, after which all finish times read as zero again.
module earliest_finish_job_assigner_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [efja_pkg::NW_W-1:0]          cfg_data,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: worker_index, worker_factor, job_size, zero fill.
  input  wire [efja_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Field: cmd.
  input  wire                               in_tuser,
  input  wire                               in_tlast,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // Fields from bit 0: assigned_worker, finish_time, makespan, zero fill.
  output logic [efja_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import efja_pkg::*;

  logic [NW_W-1:0] nw_cfg_r;
  q_stat_t         q_stat;
  logic            push;
  req_t            push_req;
  logic            pop;
  req_t            head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw_cfg_r <= NW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      nw_cfg_r <= cfg_data;
    end
  end

  efja_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_req  (push_req)
  );

  efja_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  efja_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .nw_cfg     (nw_cfg_r),
    .q_stat     (q_stat),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* hw/rtl/efja_checker.sv */
// Port-level checks for the earliest-finish job assigner, bound to the top level.
`default_nettype none

module efja_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [efja_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire                               out_tlast
);
  import efja_pkg::*;

  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] makespan;

  assign finish_time = out_tdata[WIDX_W+TIME_W-1:WIDX_W];
  assign makespan    = out_tdata[WIDX_W+2*TIME_W-1:WIDX_W+TIME_W];

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_span_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> makespan >= finish_time)
    else $error("Makespan below the finish time of the closing job.");

  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> makespan == '0)
    else $error("Makespan not zero on a result inside a batch.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result changed or dropped.");

endmodule

bind earliest_finish_job_assigner_top efja_checker u_efja_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
